### rtl/c2d_pkg.sv
`timescale 1ns / 1ps

package c2d_pkg;

  // Default frame geometry.
  localparam int unsigned ImageWidthDef  = 16;
  localparam int unsigned ImageHeightDef = 16;

  // Fixed field widths.
  localparam int unsigned PixW    = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned KRowW   = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned KSize   = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegKernelTop = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKernelMid = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKernelBot = 2'd2;

  // Reset kernel: corners and center set to one.
  localparam logic [KRowW-1:0] KernelTopRst = 48'h0001_0000_0001;
  localparam logic [KRowW-1:0] KernelMidRst = 48'h0000_0001_0000;
  localparam logic [KRowW-1:0] KernelBotRst = 48'h0001_0000_0001;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [AccW-1:0] acc_t;

endpackage

### rtl/c2d_ram.sv
`timescale 1ns / 1ps

module c2d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/conv2d_3x3_valid_stream.sv
// A result passes through the stage 1 registers, the window, the product and row-sum
// registers and the output register before it is offered on the master side.
// Throughput: one pixel per cycle while the skid register is empty, with one line memory read and one write per cycle.
// Reset (rst_ni low, asynchronous) clears position counters, window and pipeline,
// and loads the default kernel; the line memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module conv2d_3x3_valid_stream
  import c2d_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [KRowW-1:0]   cfg_data_i,

  // Pixel input stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [PixW-1:0]    s_axis_tdata_i,   // [15:0] pixel
  input  logic               s_axis_tuser_i,   // [0] frame_first

  // Result output stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [AccW-1:0]    m_axis_tdata_o,   // [31:0] conv_value
  output logic               m_axis_tlast_o    // frame_last
);

  localparam int unsigned CW = $clog2(IMAGE_WIDTH);
  localparam int unsigned RW = $clog2(IMAGE_HEIGHT);
  localparam int unsigned LW = 2 * PixW;

  // The pipeline moves as a whole whenever the skid register is empty. Because
  // ready depends only on a register, the input side keeps accepting pixels
  // while a finished result still waits in the output register.
  logic advance;
  logic accept;

  logic skid_valid_q;
  assign advance         = !skid_valid_q;
  assign s_axis_tready_o = advance;
  assign accept          = s_axis_tvalid_i && advance;

  // Kernel registers.
  logic [KRowW-1:0] kernel_q [KSize];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0] <= KernelTopRst;
      kernel_q[1] <= KernelMidRst;
      kernel_q[2] <= KernelBotRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegKernelTop: kernel_q[0] <= cfg_data_i;
        RegKernelMid: kernel_q[1] <= cfg_data_i;
        RegKernelBot: kernel_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position tracking at the input. A frame_first pixel is forced to the
  // origin; after the last pixel of a frame the counters wrap to the origin.
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic          emit_cur, last_cur;

  always_comb begin
    col_cur  = s_axis_tuser_i ? '0 : col_q;
    row_cur  = s_axis_tuser_i ? '0 : row_q;
    emit_cur = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    last_cur = (row_cur == RW'(IMAGE_HEIGHT - 1)) && (col_cur == CW'(IMAGE_WIDTH - 1));
    col_d    = col_q;
    row_d    = row_q;
    if (accept) begin
      if (col_cur == CW'(IMAGE_WIDTH - 1)) begin
        col_d = '0;
        row_d = (row_cur == RW'(IMAGE_HEIGHT - 1)) ? '0 : row_cur + RW'(1);
      end else begin
        col_d = col_cur + CW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line memory: one word per column, the low half holds the row above the
  // current one and the high half the row two above. A pixel reads its column
  // when accepted and writes the shifted pair back from stage 1 when the pipeline advances.
  logic          s1_valid_q;
  pix_t          s1_px_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_emit_q, s1_last_q;

  logic          ram_we, ram_re;
  logic [CW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata, ram_rdata;
  logic [LW-1:0] line_word;

  // A write and a read of the same column in one cycle happen only when a
  // frame restart lands on the column just written; the write data is then
  // carried over instead of the stale memory word.
  logic          fwd_q;
  logic [LW-1:0] fwd_data_q;

  assign line_word = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_we    = s1_valid_q && advance;
  assign ram_waddr = s1_col_q;
  assign ram_wdata = {line_word[PixW-1:0], s1_px_q};
  assign ram_re    = accept;

  c2d_ram #(
    .WIDTH (LW),
    .DEPTH (IMAGE_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      fwd_q      <= ram_we && (ram_waddr == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_px_q    <= s_axis_tdata_i;
      s1_col_q   <= col_cur;
      s1_emit_q  <= emit_cur;
      s1_last_q  <= last_cur;
      fwd_data_q <= ram_wdata;
    end
  end

  // Window: rows top to bottom are oldest to newest, columns left to right.
  pix_t win_q [KSize][KSize];
  pix_t win_d [KSize][KSize];

  always_comb begin
    win_d = win_q;
    if (ram_we) begin
      for (int i = 0; i < KSize; i++) begin
        win_d[i][0] = win_q[i][1];
        win_d[i][1] = win_q[i][2];
      end
      win_d[0][2] = line_word[LW-1:PixW];
      win_d[1][2] = line_word[PixW-1:0];
      win_d[2][2] = s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KSize; i++) begin
        for (int k = 0; k < KSize; k++) begin
          win_q[i][k] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
    end
  end

  // Stage 2: the window holds this pixel's neighborhood; form nine products.
  logic s2_valid_q, s2_last_q;
  logic s3_valid_q, s3_last_q;
  logic s4_valid_q, s4_last_q;
  acc_t prod_q [KSize][KSize];
  acc_t prod_d [KSize][KSize];
  acc_t rsum_q [KSize];
  acc_t rsum_d [KSize];

  always_comb begin
    for (int i = 0; i < KSize; i++) begin
      for (int k = 0; k < KSize; k++) begin
        prod_d[i][k] = acc_t'($signed(win_q[i][k]) * $signed(kernel_q[i][CoefW*k +: CoefW]));
      end
    end
    for (int i = 0; i < KSize; i++) begin
      rsum_d[i] = prod_q[i][0] + prod_q[i][1] + prod_q[i][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_last_q <= s1_last_q;
      s3_last_q <= s2_last_q;
      s4_last_q <= s3_last_q;
      prod_q    <= prod_d;
      rsum_q    <= rsum_d;
    end
  end

  // Final sum feeds the output register, with a skid register behind it.
  acc_t pipe_sum;
  assign pipe_sum = rsum_q[0] + rsum_q[1] + rsum_q[2];

  logic out_valid_q, out_last_q, skid_last_q;
  acc_t out_data_q, skid_data_q;
  logic out_load;

  assign out_load = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q  <= skid_valid_q || s4_valid_q;
      skid_valid_q <= 1'b0;
    end else if (s4_valid_q && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= skid_valid_q ? skid_data_q : pipe_sum;
      out_last_q <= skid_valid_q ? skid_last_q : s4_last_q;
    end else if (!skid_valid_q) begin
      skid_data_q <= pipe_sum;
      skid_last_q <= s4_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_fwd_same_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re && (ram_waddr == col_cur)) |=> fwd_q)
    else $error("same-column read and write were not forwarded");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < IMAGE_WIDTH) && (32'(row_q) < IMAGE_HEIGHT))
    else $error("position counter out of frame");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i) |=> ((col_q == CW'(1)) && (row_q == '0)))
    else $error("frame start did not restart the position");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import c2d_pkg::*;

  // Frame geometry under test: the block's default parameters.
  localparam int unsigned ImgW      = ImageWidthDef;
  localparam int unsigned ImgH      = ImageHeightDef;
  localparam int unsigned ImgPixels = ImgW * ImgH;

  // Index above the last kernel row: the block must drop writes to it.
  localparam logic [CfgIdxW-1:0] RegUnmapped = 2'd3;

  // Extreme sample values.
  localparam pix_t PixMin = 16'h8000;
  localparam pix_t PixMax = 16'h7FFF;

  // The pad covers pixels still in flight that cause no result, with margin.
  localparam int unsigned DrainPad      = 12;
  // Long receiver hold-off used to back the pipeline up into the input side.
  localparam int unsigned HoldLen       = 300;
  // Budget for about 2100 pixels, each with the largest sender gap and receiver
  // stall, plus the hold-off and the drains, with ample margin.
  localparam int unsigned TimeoutCycles = 300000;
  localparam int unsigned MaxPrinted    = 20;

  typedef struct packed {
    pix_t pixel;
    logic first;
  } pixel_item_t;

  typedef struct packed {
    acc_t value;
    logic last;
  } conv_out_t;

  // Pixel content chosen per frame.
  typedef enum int {
    STYLE_RANDOM,
    STYLE_MIN,
    STYLE_MAX,
    STYLE_EXTREME,
    STYLE_SMALL
  } frame_style_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;

  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [KRowW-1:0]   cfg_data = '0;

  logic               px_valid = 1'b0;
  logic               px_ready;
  pix_t               px_data = '0;
  logic               px_first = 1'b0;

  logic               res_valid;
  logic               res_ready = 1'b0;
  acc_t               res_data;
  logic               res_last;

  conv2d_3x3_valid_stream #(
    .IMAGE_WIDTH (ImgW),
    .IMAGE_HEIGHT(ImgH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(px_valid),
    .s_axis_tready_o(px_ready),
    .s_axis_tdata_i (px_data),
    .s_axis_tuser_i (px_first),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_data),
    .m_axis_tlast_o (res_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Pixels waiting to be offered, and window sums waiting to be seen.
  pixel_item_t pix_q[$];
  conv_out_t   conv_q[$];

  int unsigned err_count     = 0;
  int unsigned pixels_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_queued = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count   = 0;

  // Traffic shaping knobs; only no_idle is changed at a falling edge.
  bit          no_idle    = 1'b0;
  logic        hold_start = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned send_gap   = 0;
  int unsigned rx_wait    = 0;

  // The generator's view of whether the stream sits at a frame boundary.
  bit          frame_aligned = 1'b0;

  // Shadow of the block: kernel rows, the two previous image rows by column,
  // the 3x3 window (row 0 is the oldest image row) and the raster position.
  logic [KRowW-1:0] kern_rows [KSize] = '{KernelTopRst, KernelMidRst, KernelBotRst};
  pix_t             line_mem  [2][ImgW];
  pix_t             win       [KSize][KSize];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
  end

  task automatic report_mismatch(input string what);
    if (err_count < MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $realtime, what);
    end
    err_count++;
  endtask

  // Advances the shadow by one accepted pixel and queues the window sum when
  // the pixel completes a window that lies fully inside the frame.
  function automatic void conv_predict(input pix_t pixel, input logic first);
    int unsigned      c;
    int unsigned      r;
    logic [AccW-1:0]  sum;
    logic signed [AccW-1:0] prod;
    conv_out_t        res;
    if (first) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= ImgW) col_pos = 0;
    if (row_pos >= ImgH) row_pos = 0;
    c = col_pos;
    r = row_pos;

    for (int i = 0; i < KSize; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_mem[1][c];
    win[1][2] = line_mem[0][c];
    win[2][2] = pixel;
    line_mem[1][c] = line_mem[0][c];
    line_mem[0][c] = pixel;

    if (c + 1 >= ImgW) begin
      col_pos = 0;
      row_pos = (r + 1 >= ImgH) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end

    if (r >= 2 && c >= 2) begin
      // Products are formed at 32 bits and the sum wraps at 32 bits.
      sum = '0;
      for (int i = 0; i < KSize; i++) begin
        for (int k = 0; k < KSize; k++) begin
          prod = $signed(win[i][k]) * $signed(kern_rows[i][CoefW*k +: CoefW]);
          sum  = sum + prod;
        end
      end
      res.value = sum;
      res.last  = (r == ImgH - 1) && (c == ImgW - 1);
      conv_q.push_back(res);
    end
  endfunction

  // Sender: offers the queued pixels in order, with a random gap drawn after
  // each one unless no_idle is set. The shadow advances on every input transfer.
  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_item_t nxt;
    if (!rst_ni) begin
      px_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (px_valid && px_ready) begin
        conv_predict(px_data, px_first);
        pixels_sent++;
      end
      if (!px_valid || px_ready) begin
        if (send_gap != 0) begin
          px_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pix_q.size() != 0) begin
          nxt = pix_q.pop_front();
          px_valid <= 1'b1;
          px_data  <= nxt.pixel;
          px_first <= nxt.first;
          send_gap <= no_idle ? 0 : $urandom_range(0, 10);
        end else begin
          px_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output transfer against the oldest expected sum,
  // then stalls for a randomly drawn number of cycles unless no_idle is set.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    conv_out_t   want;
    int unsigned stall;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      stall = (rx_wait != 0) ? rx_wait - 1 : 0;
      if (res_valid && res_ready) begin
        if (conv_q.size() == 0) begin
          report_mismatch($sformatf("result %08h arrived with nothing expected", res_data));
        end else begin
          want = conv_q.pop_front();
          if (res_data !== want.value) begin
            report_mismatch($sformatf("conv_value %08h, expected %08h",
                                      res_data, want.value));
          end
          if (res_last !== want.last) begin
            report_mismatch($sformatf("frame_last %b, expected %b", res_last, want.last));
          end
        end
        results_seen++;
        stall = no_idle ? 0 : $urandom_range(0, 10);
      end
      rx_wait   <= stall;
      res_ready <= (hold_left == 0) && (stall == 0);
    end
  end

  // Long hold-off of the receiver, counted down on its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HoldLen;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("Timeout after %0d cycles, %0d sums still expected",
               cycle_count, conv_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic pix_t pick_pixel(input frame_style_e style);
    pix_t p;
    case (style)
      STYLE_MIN: p = PixMin;
      STYLE_MAX: p = PixMax;
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       p = PixMin;
          1:       p = PixMax;
          2:       p = '0;
          default: p = '1;
        endcase
      end
      STYLE_SMALL: p = pix_t'($urandom_range(0, 15)) - pix_t'(8);
      default:     p = pix_t'($urandom());
    endcase
    return p;
  endfunction

  // One kernel row: each coefficient is an extreme or a random value.
  function automatic logic [KRowW-1:0] pick_kernel_row();
    logic [KRowW-1:0] row;
    for (int k = 0; k < KSize; k++) begin
      case ($urandom_range(0, 3))
        0:       row[CoefW*k +: CoefW] = PixMin;
        1:       row[CoefW*k +: CoefW] = PixMax;
        default: row[CoefW*k +: CoefW] = CoefW'($urandom());
      endcase
    end
    return row;
  endfunction

  // Queues one frame. Mostly whole frames that start with frame_first; with
  // allow_cut some are cut short (the next one then restarts the position) and
  // a rare stray frame_first lands in the middle of a frame; some follow a
  // whole frame without frame_first.
  task automatic queue_frame(input frame_style_e style, input bit allow_cut);
    int unsigned n;
    bit          stray;
    pixel_item_t item;
    n     = ImgPixels;
    stray = 1'b0;
    if (allow_cut && $urandom_range(0, 4) == 0) n = $urandom_range(1, ImgPixels - 1);
    for (int unsigned j = 0; j < n; j++) begin
      item.pixel = pick_pixel(style);
      if (j == 0) begin
        item.first = frame_aligned ? ($urandom_range(0, 3) != 0) : 1'b1;
      end else begin
        item.first = allow_cut && ($urandom_range(0, 399) == 0);
        stray      = stray | item.first;
      end
      pix_q.push_back(item);
    end
    frame_aligned = (n == ImgPixels) && !stray;
    frames_queued++;
  endtask

  // Waits at falling edges until the sender has nothing left and every
  // expected sum has come back, then lets the pipeline run dry.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pix_q.size() != 0 || px_valid || conv_q.size() != 0);
    repeat (DrainPad) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [KRowW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      RegKernelTop: kern_rows[0] = data;
      RegKernelMid: kern_rows[1] = data;
      RegKernelBot: kern_rows[2] = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_kernel(input logic [KRowW-1:0] top, input logic [KRowW-1:0] mid,
                             input logic [KRowW-1:0] bot);
    cfg_write(RegKernelTop, top);
    cfg_write(RegKernelMid, mid);
    cfg_write(RegKernelBot, bot);
    @(negedge clk_i);
    settings_used++;
  endtask

  // Short opening sequence: extreme and patterned samples, a restart in the
  // middle of the first row, and a second stray restart.
  pix_t dir_px [20] = '{
    16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFE,
    16'h8001, 16'h8000, 16'h7FFF, 16'h1234, 16'hEDCB, 16'h0000, 16'hFFFF, 16'h8000,
    16'h7FFF, 16'h00FF, 16'hFF00, 16'h0F0F
  };

  initial begin
    pixel_item_t item;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset kernel, idling on both sides.
    for (int j = 0; j < 20; j++) begin
      item.pixel = dir_px[j];
      item.first = (j == 0) || (j == 9) || (j == 15);
      pix_q.push_back(item);
    end
    frame_aligned = 1'b0;
    queue_frame(STYLE_RANDOM, 1'b0);
    wait_drained();

    // Most negative kernel on the most negative image: every sum wraps.
    no_idle = 1'b1;
    load_kernel({3{PixMin}}, {3{PixMin}}, {3{PixMin}});
    queue_frame(STYLE_MIN, 1'b0);
    wait_drained();

    // Most positive kernel on a mix of extremes.
    no_idle = 1'b0;
    load_kernel({3{PixMax}}, {3{PixMax}}, {3{PixMax}});
    queue_frame(STYLE_EXTREME, 1'b0);
    wait_drained();

    // Random kernel, plus a write to the unmapped index that must be dropped.
    // The receiver then holds off while the sender streams without gaps, so
    // the pipeline backs up and the input side has to stall.
    no_idle = 1'b1;
    cfg_write(RegUnmapped, {KRowW{1'b1}});
    load_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    cfg_write(RegUnmapped, KRowW'({$urandom(), $urandom()}));
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    @(negedge clk_i);
    queue_frame(STYLE_RANDOM, 1'b0);
    wait_drained();

    // Random kernels and random traffic.
    for (int ph = 0; ph < 3; ph++) begin
      no_idle = (ph == 2);
      load_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      queue_frame(frame_style_e'($urandom_range(0, 4)), 1'b1);
      wait_drained();
    end

    // Back to the reset kernel, written explicitly.
    no_idle = 1'b0;
    load_kernel(KernelTopRst, KernelMidRst, KernelBotRst);
    queue_frame(STYLE_MAX, 1'b0);
    wait_drained();

    $display("Summary: %0d pixels in %0d frames under %0d kernel settings, %0d sums checked.",
             pixels_sent, frames_queued, settings_used, results_seen);
    $display("Covered wrapping sums, restarts, streams past frame end and output back-pressure.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
